>>> sv/aapr_pkg.sv
// Shared types, constants and the CORDIC angle table of the axis-angle rotation unit.
package aapr_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 30;
  localparam int unsigned SQRT_STEPS       = 32;
  localparam int unsigned DIV_STEPS        = 29;
  localparam int unsigned FRAC_BITS        = 28;

  localparam logic signed [33:0] Q_PI       = 34'sd843314857;
  localparam logic signed [33:0] Q_TWO_PI   = 34'sd1686629713;
  localparam logic signed [33:0] Q_HALF_PI  = 34'sd421657428;
  localparam logic signed [31:0] Q_GAIN     = 32'sd163008219;
  localparam logic signed [31:0] Q_ONE      = 32'sd268435456;
  localparam logic signed [63:0] Q_HALF     = 64'sd134217728;
  localparam logic signed [33:0] Q_MAT_MAX  = 34'sd536870912;

  // Arctangent of 2^-i in Q4.28; past the table it is 2^-i itself, or zero below 2^-28.
  function automatic logic signed [31:0] atan_step(input int unsigned i);
    logic signed [31:0] v;
    case (i)
      0:       v = 32'sd210828714;
      1:       v = 32'sd124459457;
      2:       v = 32'sd65760959;
      3:       v = 32'sd33381290;
      4:       v = 32'sd16755422;
      5:       v = 32'sd8385879;
      6:       v = 32'sd4193963;
      7:       v = 32'sd2097109;
      8:       v = 32'sd1048571;
      9:       v = 32'sd524287;
      default: v = (i <= FRAC_BITS) ? 32'(64'd1 << (FRAC_BITS - i)) : 32'sd0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] c;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [2:0][31:0] axis;
    logic [63:0]      n;
    logic [63:0]      r;
  } sqrt_t;

  typedef struct packed {
    side_t            side;
    logic             pass;
    logic [31:0]      theta;
    logic [2:0]       neg;
    logic [2:0][60:0] rem;
    logic [2:0][28:0] q;
  } div_t;

  typedef struct packed {
    side_t              side;
    logic               pass;
    logic [2:0][29:0]   u;
    logic               neg;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rot_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic             unchanged;
    logic             clipped;
  } res_t;

endpackage

>>> sv/axis_angle_point_rotation_unit.sv
// Top level of the axis-angle point rotation unit: input stages, cell chains and output.
//
// Each item on the slave stream carries a point, a rotation vector (angle times
// unit axis, Q4.28 radians) and a centre (Q16.16). The unit rotates the point
// about the centre by the Rodrigues formula and sends one result item on the
// master stream: the new point, a flag for pass-through and a flag for
// saturation. Rotations whose angle lies below min_angle, and a zero vector,
// return the point unchanged.
// The whole datapath is one pipeline of cells: squares and sum, 32 square-root
// cells, 29 division cells for the unit axis, angle reduction, CORDIC_STEPS
// CORDIC cells and six stages for matrix and product. One item is taken every
// cycle while the receiver does not stall. When the receiver stalls with a
// result waiting, the pipeline holds and s_axis_tready falls; it rises again
// as soon as that result is taken. min_angle is written through the cfg
// channel, which is always ready, and must only change while no item is in
// flight. Reset empties the pipeline and sets min_angle to 1.
module axis_angle_point_rotation_unit #(
  parameter int unsigned COORD_WIDTH  = aapr_pkg::COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = aapr_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: point_x, point_y, point_z, axis_x, axis_y, axis_z,
  //        center_x, center_y, center_z (32 bits each, lowest first)
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  // tdata: out_x, out_y, out_z (32 bits each, lowest first)
  // tuser: left_unchanged (bit 0), clipped (bit 1)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,
  output logic [1:0]   m_axis_tuser,
  // Threshold register write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i
);
  import aapr_pkg::*;

  logic en;
  logic [30:0] min_angle_q;

  // The whole pipeline advances unless a finished result is held back.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q <= 31'd1;
    end else if (cfg_valid_i) begin
      min_angle_q <= cfg_data_i;
    end
  end

  // First stage: unpack the item and square the rotation vector components.
  logic               s1_valid_q;
  side_t              s1_side_q;
  logic [2:0][31:0]   s1_axis_q;
  logic [63:0]        s1_sq_q [3];
  logic signed [63:0] ax_ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) ax_ext[i] = 64'($signed(s_axis_tdata[32 * (3 + i) +: 32]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_side_q.p[i] <= s_axis_tdata[32 * i +: 32];
        s1_axis_q[i]   <= s_axis_tdata[32 * (3 + i) +: 32];
        s1_side_q.c[i] <= s_axis_tdata[32 * (6 + i) +: 32];
        s1_sq_q[i]     <= ax_ext[i] * ax_ext[i];
      end
    end
  end

  // Second stage: sum of squares, which starts the square root.
  logic [SQRT_STEPS:0] sq_vld;
  sqrt_t               sq_pipe [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sq_vld[0]  <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
      sq_vld[0]  <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_pipe[0].side <= s1_side_q;
      sq_pipe[0].axis <= s1_axis_q;
      sq_pipe[0].n    <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
      sq_pipe[0].r    <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    aapr_sqrt_cell #(.K(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[k]),
      .data_i  (sq_pipe[k]),
      .valid_o (sq_vld[k+1]),
      .data_o  (sq_pipe[k+1])
    );
  end

  // Threshold decision and division set-up: the angle is the root, the
  // dividends are the component magnitudes scaled to Q28.
  logic [DIV_STEPS:0] dv_vld;
  div_t               dv_pipe [DIV_STEPS+1];
  div_t               dv_d;
  logic [31:0]        theta;
  logic [31:0]        mag;

  always_comb begin
    theta       = sq_pipe[SQRT_STEPS].r[31:0];
    dv_d.side   = sq_pipe[SQRT_STEPS].side;
    dv_d.theta  = theta;
    dv_d.pass   = (theta == 32'd0) || (theta < 32'(min_angle_q));
    dv_d.q      = '0;
    mag         = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d.neg[i] = sq_pipe[SQRT_STEPS].axis[i][31];
      mag         = dv_d.neg[i] ? -sq_pipe[SQRT_STEPS].axis[i] : sq_pipe[SQRT_STEPS].axis[i];
      dv_d.rem[i] = 61'(mag) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_pipe[0] <= dv_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    aapr_div_cell #(.B(DIV_STEPS - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[k]),
      .data_i  (dv_pipe[k]),
      .valid_o (dv_vld[k+1]),
      .data_o  (dv_pipe[k+1])
    );
  end

  // Angle reduction into (-pi, pi] and the signed unit axis.
  logic               rd_valid_q;
  rot_t               rd_q, rd_d;
  logic signed [33:0] zr;
  logic [29:0]        qe;

  always_comb begin
    zr        = 34'(dv_pipe[DIV_STEPS].theta);
    for (int k = 0; k < 3; k++) begin
      if (zr > Q_PI) zr = zr - Q_TWO_PI;
    end
    rd_d.side = dv_pipe[DIV_STEPS].side;
    rd_d.pass = dv_pipe[DIV_STEPS].pass;
    for (int i = 0; i < 3; i++) begin
      qe        = 30'(dv_pipe[DIV_STEPS].q[i]);
      rd_d.u[i] = dv_pipe[DIV_STEPS].neg[i] ? -qe : qe;
    end
    rd_d.neg  = 1'b0;
    rd_d.x    = Q_GAIN;
    rd_d.y    = '0;
    rd_d.z    = zr[31:0];
  end

  // Fold into [-pi/2, pi/2]; a fold negates cosine and sine at the end.
  logic [CORDIC_STEPS:0] cr_vld;
  rot_t                  cr_pipe [CORDIC_STEPS+1];
  rot_t                  fd_d;
  logic signed [33:0]    zf;

  always_comb begin
    fd_d = rd_q;
    zf   = 34'(rd_q.z);
    if (zf > Q_HALF_PI) begin
      zf       = zf - Q_PI;
      fd_d.neg = 1'b1;
    end else if (zf < -Q_HALF_PI) begin
      zf       = zf + Q_PI;
      fd_d.neg = 1'b1;
    end
    fd_d.z = zf[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      cr_vld[0]  <= 1'b0;
    end else if (en) begin
      rd_valid_q <= dv_vld[DIV_STEPS];
      cr_vld[0]  <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q       <= rd_d;
      cr_pipe[0] <= fd_d;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    aapr_cordic_cell #(.I(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cr_vld[k]),
      .data_i  (cr_pipe[k]),
      .valid_o (cr_vld[k+1]),
      .data_o  (cr_pipe[k+1])
    );
  end

  // Matrix, product and saturation; its last register is the output register.
  res_t res;

  aapr_rodrigues #(.COORD_WIDTH(COORD_WIDTH)) u_rodrigues (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cr_vld[CORDIC_STEPS]),
    .data_i  (cr_pipe[CORDIC_STEPS]),
    .valid_o (m_axis_tvalid),
    .data_o  (res)
  );

  assign m_axis_tdata = {res.o[2], res.o[1], res.o[0]};
  assign m_axis_tuser = {res.clipped, res.unchanged};

endmodule

>>> sv/aapr_sqrt_cell.sv
// One step of the integer square root: settles one bit of the root.
module aapr_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  aapr_pkg::sqrt_t data_i,
  output logic           valid_o,
  output aapr_pkg::sqrt_t data_o
);
  import aapr_pkg::*;

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * K);

  logic [63:0] trial;
  sqrt_t       data_d, data_q;
  logic        valid_q;

  always_comb begin
    trial  = data_i.r + Bit;
    data_d = data_i;
    if (data_i.n >= trial) begin
      data_d.n = data_i.n - trial;
      data_d.r = (data_i.r >> 1) + Bit;
    end else begin
      data_d.r = data_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/aapr_div_cell.sv
// One restoring division step: one quotient bit for each of the three axis lanes.
module aapr_div_cell #(
  parameter int unsigned B = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  aapr_pkg::div_t data_i,
  output logic          valid_o,
  output aapr_pkg::div_t data_o
);
  import aapr_pkg::*;

  logic [60:0] divisor;
  div_t        data_d, data_q;
  logic        valid_q;

  always_comb begin
    divisor = 61'(data_i.theta) << B;
    data_d  = data_i;
    for (int l = 0; l < 3; l++) begin
      if (data_i.rem[l] >= divisor) begin
        data_d.rem[l]  = data_i.rem[l] - divisor;
        data_d.q[l][B] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/aapr_cordic_cell.sv
// One CORDIC rotation iteration towards the residual angle.
module aapr_cordic_cell #(
  parameter int unsigned I = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  aapr_pkg::rot_t data_i,
  output logic          valid_o,
  output aapr_pkg::rot_t data_o
);
  import aapr_pkg::*;

  localparam logic signed [31:0] Step = atan_step(I);

  logic signed [31:0] xs, ys;
  rot_t               data_d, data_q;
  logic               valid_q;

  always_comb begin
    xs     = data_i.x >>> I;
    ys     = data_i.y >>> I;
    data_d = data_i;
    if (!data_i.z[31]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - Step;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/aapr_rodrigues.sv
// Rotation matrix build, matrix-vector product about the centre and saturation.
module aapr_rodrigues #(
  parameter int unsigned COORD_WIDTH = aapr_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  aapr_pkg::rot_t data_i,
  output logic          valid_o,
  output aapr_pkg::res_t data_o
);
  import aapr_pkg::*;

  localparam int unsigned Cwe = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int unsigned Sh  = 32 - Cwe;
  localparam logic signed [39:0] Hi = (40'sd1 <<< (Cwe - 1)) - 40'sd1;
  localparam logic signed [39:0] Lo = -Hi - 40'sd1;

  function automatic logic signed [32:0] sx(input logic [31:0] v);
    logic [31:0] t;
    t = v << Sh;
    return 33'($signed(t) >>> Sh);
  endfunction

  function automatic logic signed [31:0] rnd28(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + Q_HALF) >>> FRAC_BITS;
    return t[31:0];
  endfunction

  // Stage 1: axis products and axis times sine.
  logic [5:0] valid_q;
  logic signed [31:0] cs, sn;
  logic signed [29:0] ua [3];
  logic signed [59:0] puu [6];
  logic signed [61:0] pus [3];
  logic signed [31:0] uu1_q [6];
  logic signed [31:0] us1_q [3];
  logic signed [31:0] cs1_q, t1_q;
  side_t              side1_q;
  logic               pass1_q;

  always_comb begin
    cs = data_i.neg ? -data_i.x : data_i.x;
    sn = data_i.neg ? -data_i.y : data_i.y;
    for (int i = 0; i < 3; i++) begin
      ua[i]  = $signed(data_i.u[i]);
      pus[i] = ua[i] * sn;
    end
    puu[0] = ua[0] * ua[0];
    puu[1] = ua[1] * ua[1];
    puu[2] = ua[2] * ua[2];
    puu[3] = ua[0] * ua[1];
    puu[4] = ua[0] * ua[2];
    puu[5] = ua[1] * ua[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) uu1_q[k] <= rnd28(64'(puu[k]));
      for (int k = 0; k < 3; k++) us1_q[k] <= rnd28(64'(pus[k]));
      cs1_q   <= cs;
      t1_q    <= Q_ONE - cs;
      side1_q <= data_i.side;
      pass1_q <= data_i.pass;
    end
  end

  // Stage 2: scale the outer product by one minus cosine.
  logic signed [31:0] ut2_q [6];
  logic signed [31:0] us2_q [3];
  logic signed [31:0] cs2_q;
  side_t              side2_q;
  logic               pass2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) ut2_q[k] <= rnd28(uu1_q[k] * t1_q);
      us2_q   <= us1_q;
      cs2_q   <= cs1_q;
      side2_q <= side1_q;
      pass2_q <= pass1_q;
    end
  end

  // Stage 3: matrix entries, clamped to plus or minus two; offsets from the centre.
  logic signed [33:0] ms [9];
  logic signed [33:0] cs34, ut34 [6], us34 [3];
  logic signed [30:0] m3_q [9];
  logic signed [32:0] d3_q [3];
  side_t              side3_q;
  logic               pass3_q;

  always_comb begin
    cs34 = 34'(cs2_q);
    for (int k = 0; k < 6; k++) ut34[k] = 34'(ut2_q[k]);
    for (int k = 0; k < 3; k++) us34[k] = 34'(us2_q[k]);
    ms[0] = cs34 + ut34[0];
    ms[1] = ut34[3] - us34[2];
    ms[2] = ut34[4] + us34[1];
    ms[3] = ut34[3] + us34[2];
    ms[4] = cs34 + ut34[1];
    ms[5] = ut34[5] - us34[0];
    ms[6] = ut34[4] - us34[1];
    ms[7] = ut34[5] + us34[0];
    ms[8] = cs34 + ut34[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        if (ms[k] > Q_MAT_MAX) begin
          m3_q[k] <= 31'(Q_MAT_MAX);
        end else if (ms[k] < -Q_MAT_MAX) begin
          m3_q[k] <= 31'(-Q_MAT_MAX);
        end else begin
          m3_q[k] <= 31'(ms[k]);
        end
      end
      for (int j = 0; j < 3; j++) d3_q[j] <= sx(side2_q.p[j]) - sx(side2_q.c[j]);
      side3_q <= side2_q;
      pass3_q <= pass2_q;
    end
  end

  // Stage 4: the nine products.
  logic signed [63:0] pr4_q [9];
  side_t              side4_q;
  logic               pass4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) pr4_q[k] <= 64'(m3_q[k]) * 64'(d3_q[k % 3]);
      side4_q <= side3_q;
      pass4_q <= pass3_q;
    end
  end

  // Stage 5: row sums rounded to the coordinate grid.
  logic signed [65:0] acc [3];
  logic signed [65:0] accr [3];
  logic signed [37:0] o5_q [3];
  side_t              side5_q;
  logic               pass5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = 66'(pr4_q[3 * i]) + 66'(pr4_q[3 * i + 1]) + 66'(pr4_q[3 * i + 2]);
      accr[i] = (acc[i] + 66'(Q_HALF)) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) o5_q[i] <= accr[i][37:0];
      side5_q <= side4_q;
      pass5_q <= pass4_q;
    end
  end

  // Stage 6: add the centre back, saturate, or pass the point through.
  logic signed [39:0] o6 [3];
  res_t               res_d, res_q;

  always_comb begin
    res_d = '0;
    for (int i = 0; i < 3; i++) begin
      o6[i] = 40'(o5_q[i]) + 40'(sx(side5_q.c[i]));
      if (o6[i] > Hi) begin
        o6[i]         = Hi;
        res_d.clipped = 1'b1;
      end else if (o6[i] < Lo) begin
        o6[i]         = Lo;
        res_d.clipped = 1'b1;
      end
      res_d.o[i] = o6[i][31:0];
    end
    if (pass5_q) begin
      for (int i = 0; i < 3; i++) res_d.o[i] = 32'(sx(side5_q.p[i]));
      res_d.unchanged = 1'b1;
      res_d.clipped   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[4:0], valid_i};
    end
  end

  assign valid_o = valid_q[5];
  assign data_o  = res_q;

endmodule
